### rtl/core/gpio_ed_pkg.sv
// Package for the GPIO edge-detect block: widths, op and word-address codes, helpers.
package gpio_ed_pkg;

  localparam int NumPins     = 54;
  localparam int PinsLow     = 32;
  localparam int PinsHigh    = NumPins - PinsLow;
  localparam int FselWords   = 6;
  localparam int FieldBits   = 3;
  localparam int PinsPerWord = 10;
  localparam int FselBits    = FieldBits * PinsPerWord;

  typedef logic [NumPins-1:0]  pin_vec_t;
  typedef logic [FselBits-1:0] fsel_word_t;

  typedef enum logic [1:0] {
    OpRead   = 2'd0,
    OpWrite  = 2'd1,
    OpSample = 2'd2,
    OpIdle   = 2'd3
  } op_e;

  // Register word offsets
  localparam logic [5:0] AddrFselLast = 6'd5;
  localparam logic [5:0] AddrSetLo    = 6'd7;
  localparam logic [5:0] AddrSetHi    = 6'd8;
  localparam logic [5:0] AddrClrLo    = 6'd10;
  localparam logic [5:0] AddrClrHi    = 6'd11;
  localparam logic [5:0] AddrLevLo    = 6'd13;
  localparam logic [5:0] AddrLevHi    = 6'd14;
  localparam logic [5:0] AddrEdsLo    = 6'd16;
  localparam logic [5:0] AddrEdsHi    = 6'd17;
  localparam logic [5:0] AddrRenLo    = 6'd19;
  localparam logic [5:0] AddrRenHi    = 6'd20;

  localparam logic [FieldBits-1:0] FuncOutput = 3'b001;

  // Field mask of one function-select word: only fields of existing pins.
  function automatic fsel_word_t fsel_mask(input logic [2:0] w);
    fsel_word_t m;
    m = '0;
    for (int k = 0; k < PinsPerWord; k++) begin
      if (int'(w) * PinsPerWord + k < NumPins) begin
        m[FieldBits*k +: FieldBits] = '1;
      end
    end
    return m;
  endfunction

  // Put a bus word onto the low or high half of the pin vector.
  function automatic pin_vec_t place(input logic [31:0] v, input logic hi);
    pin_vec_t r;
    if (hi) begin
      r = {v[PinsHigh-1:0], {PinsLow{1'b0}}};
    end else begin
      r = {{PinsHigh{1'b0}}, v};
    end
    return r;
  endfunction

  // Read back one half of a pin vector as a bus word.
  function automatic logic [31:0] half(input pin_vec_t v, input logic hi);
    logic [31:0] r;
    if (hi) begin
      r = 32'(v[NumPins-1:PinsLow]);
    end else begin
      r = v[PinsLow-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/gpio_controller_edge_detect_unit.sv
// GPIO register block with rising-edge event detection: top level.
//
// Usage:
//   One input channel (in_valid_i / in_ready_o) carries a bus read, a bus
//   write or a pin-sample tick per transfer; op_i selects which. One output
//   channel (out_valid_o / out_ready_i) returns exactly one result per input
//   transfer: read data (zero for writes, ticks, idle and unmapped words) plus
//   the output latch, the per-pin drive enables and the any-event flag, all
//   as they stand after the transfer took effect.
//   Result: registered, appearing the cycle after the input transfer.
//   Throughput: one transfer per cycle while the receiver keeps out_ready_i
//   high; register update and result form in a single pass of decode logic.
//   Stall: with a result held and out_ready_i low, in_ready_o drops; state
//   and the held result stay unchanged until the result is taken.
//   Reset: all pins input, output latch, rise enables, event status and the
//   sampled levels cleared; no result pending.
module gpio_controller_edge_detect_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         op_i,
  input  logic [5:0]                         word_addr_i,
  input  logic [31:0]                        write_data_i,
  input  logic [31:0]                        pin_in_low_i,
  input  logic [gpio_ed_pkg::PinsHigh-1:0]   pin_in_high_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [31:0]                        read_data_o,
  output logic [31:0]                        pin_out_low_o,
  output logic [gpio_ed_pkg::PinsHigh-1:0]   pin_out_high_o,
  output logic [31:0]                        drive_low_o,
  output logic [gpio_ed_pkg::PinsHigh-1:0]   drive_high_o,
  output logic                               event_any_o
);

  // Architectural state
  gpio_ed_pkg::fsel_word_t fsel_q [gpio_ed_pkg::FselWords];
  gpio_ed_pkg::fsel_word_t fsel_d [gpio_ed_pkg::FselWords];
  gpio_ed_pkg::pin_vec_t   latch_q, latch_d;
  gpio_ed_pkg::pin_vec_t   ren_q,   ren_d;
  gpio_ed_pkg::pin_vec_t   evt_q,   evt_d;
  gpio_ed_pkg::pin_vec_t   lev_q,   lev_d;

  // Result register
  logic                    out_valid_q;
  logic [31:0]             rd_q;
  gpio_ed_pkg::pin_vec_t   latch_out_q;
  gpio_ed_pkg::pin_vec_t   drive_q;
  logic                    evt_any_q;

  logic                    in_fire;
  logic [31:0]             rd_d;
  gpio_ed_pkg::pin_vec_t   drive_d;
  gpio_ed_pkg::pin_vec_t   pins;

  // Result slot frees up when it is empty or being taken this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign pins       = {pin_in_high_i, pin_in_low_i};

  // Register update and read decode for the current transfer
  always_comb begin
    fsel_d  = fsel_q;
    latch_d = latch_q;
    ren_d   = ren_q;
    evt_d   = evt_q;
    lev_d   = lev_q;
    rd_d    = '0;
    case (op_i)
      gpio_ed_pkg::OpRead: begin
        if (word_addr_i <= gpio_ed_pkg::AddrFselLast) begin
          rd_d = 32'(fsel_q[word_addr_i[2:0]]);
        end else if (word_addr_i inside {gpio_ed_pkg::AddrLevLo, gpio_ed_pkg::AddrLevHi}) begin
          rd_d = gpio_ed_pkg::half(lev_q, word_addr_i == gpio_ed_pkg::AddrLevHi);
        end else if (word_addr_i inside {gpio_ed_pkg::AddrEdsLo, gpio_ed_pkg::AddrEdsHi}) begin
          rd_d = gpio_ed_pkg::half(evt_q, word_addr_i == gpio_ed_pkg::AddrEdsHi);
        end else if (word_addr_i inside {gpio_ed_pkg::AddrRenLo, gpio_ed_pkg::AddrRenHi}) begin
          rd_d = gpio_ed_pkg::half(ren_q, word_addr_i == gpio_ed_pkg::AddrRenHi);
        end
      end
      gpio_ed_pkg::OpWrite: begin
        if (word_addr_i <= gpio_ed_pkg::AddrFselLast) begin
          fsel_d[word_addr_i[2:0]] = write_data_i[gpio_ed_pkg::FselBits-1:0]
                                     & gpio_ed_pkg::fsel_mask(word_addr_i[2:0]);
        end else if (word_addr_i inside {gpio_ed_pkg::AddrSetLo, gpio_ed_pkg::AddrSetHi}) begin
          latch_d = latch_q | gpio_ed_pkg::place(write_data_i,
                                                 word_addr_i == gpio_ed_pkg::AddrSetHi);
        end else if (word_addr_i inside {gpio_ed_pkg::AddrClrLo, gpio_ed_pkg::AddrClrHi}) begin
          latch_d = latch_q & ~gpio_ed_pkg::place(write_data_i,
                                                  word_addr_i == gpio_ed_pkg::AddrClrHi);
        end else if (word_addr_i inside {gpio_ed_pkg::AddrEdsLo, gpio_ed_pkg::AddrEdsHi}) begin
          // write one to clear
          evt_d = evt_q & ~gpio_ed_pkg::place(write_data_i,
                                              word_addr_i == gpio_ed_pkg::AddrEdsHi);
        end else if (word_addr_i == gpio_ed_pkg::AddrRenLo) begin
          ren_d = {ren_q[gpio_ed_pkg::NumPins-1:gpio_ed_pkg::PinsLow], write_data_i};
        end else if (word_addr_i == gpio_ed_pkg::AddrRenHi) begin
          ren_d = {write_data_i[gpio_ed_pkg::PinsHigh-1:0],
                   ren_q[gpio_ed_pkg::PinsLow-1:0]};
        end
      end
      gpio_ed_pkg::OpSample: begin
        // rising edge on an enabled pin
        evt_d = evt_q | (pins & ~lev_q & ren_q);
        lev_d = pins;
      end
      default: begin
      end
    endcase
  end

  // Drive enables follow the updated function select
  always_comb begin
    drive_d = '0;
    for (int w = 0; w < gpio_ed_pkg::FselWords; w++) begin
      for (int k = 0; k < gpio_ed_pkg::PinsPerWord; k++) begin
        if (w * gpio_ed_pkg::PinsPerWord + k < gpio_ed_pkg::NumPins) begin
          drive_d[w * gpio_ed_pkg::PinsPerWord + k] =
            (fsel_d[w][gpio_ed_pkg::FieldBits*k +: gpio_ed_pkg::FieldBits]
             == gpio_ed_pkg::FuncOutput);
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < gpio_ed_pkg::FselWords; w++) begin
        fsel_q[w] <= '0;
      end
      latch_q <= '0;
      ren_q   <= '0;
      evt_q   <= '0;
      lev_q   <= '0;
    end else if (in_fire) begin
      fsel_q  <= fsel_d;
      latch_q <= latch_d;
      ren_q   <= ren_d;
      evt_q   <= evt_d;
      lev_q   <= lev_d;
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q        <= rd_d;
      latch_out_q <= latch_d;
      drive_q     <= drive_d;
      evt_any_q   <= |evt_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = rd_q;
  assign pin_out_low_o  = latch_out_q[gpio_ed_pkg::PinsLow-1:0];
  assign pin_out_high_o = latch_out_q[gpio_ed_pkg::NumPins-1:gpio_ed_pkg::PinsLow];
  assign drive_low_o    = drive_q[gpio_ed_pkg::PinsLow-1:0];
  assign drive_high_o   = drive_q[gpio_ed_pkg::NumPins-1:gpio_ed_pkg::PinsLow];
  assign event_any_o    = evt_any_q;

  // Held result agrees with the event status it was formed from
  a_evt_any_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_any_o == (|evt_q)))
    else $error("event_any disagrees with event status");

  // Held result shows the current output latch
  a_latch_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({pin_out_high_o, pin_out_low_o} == latch_q))
    else $error("pin_out disagrees with output latch");

  // A write to the LEV words leaves the sampled levels alone
  a_lev_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op_i == gpio_ed_pkg::OpWrite
     && (word_addr_i == gpio_ed_pkg::AddrLevLo || word_addr_i == gpio_ed_pkg::AddrLevHi))
    |=> $stable(lev_q))
    else $error("LEV changed on a write");

  // A read leaves the output latch, event status, rise enables and sampled levels unchanged
  a_read_no_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op_i == gpio_ed_pkg::OpRead)
    |=> ($stable(latch_q) && $stable(evt_q) && $stable(ren_q) && $stable(lev_q)))
    else $error("state changed on a read");

endmodule

### test/tb_gpio_controller_edge_detect_unit.sv
// Self-checking testbench for the GPIO register block with rising-edge event detection.
`timescale 1ns / 100ps

module tb_gpio_controller_edge_detect_unit;

  // One response of the block: the read word plus the pin-side view after the transfer.
  typedef struct packed {
    logic [31:0]                     read_data;
    logic [31:0]                     pin_out_low;
    logic [gpio_ed_pkg::PinsHigh-1:0] pin_out_high;
    logic [31:0]                     drive_low;
    logic [gpio_ed_pkg::PinsHigh-1:0] drive_high;
    logic                            event_any;
  } gpio_resp_t;

  // Clock, reset and channel signals; every input has a known value from time 0.
  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_valid   = 1'b0;
  logic                             in_ready;
  logic [1:0]                       in_op      = gpio_ed_pkg::OpIdle;
  logic [5:0]                       in_addr    = '0;
  logic [31:0]                      in_wdata   = '0;
  logic [31:0]                      in_pins_lo = '0;
  logic [gpio_ed_pkg::PinsHigh-1:0] in_pins_hi = '0;
  logic                             out_valid;
  logic                             out_ready  = 1'b0;
  logic [31:0]                      rd_data;
  logic [31:0]                      pout_lo;
  logic [gpio_ed_pkg::PinsHigh-1:0] pout_hi;
  logic [31:0]                      drv_lo;
  logic [gpio_ed_pkg::PinsHigh-1:0] drv_hi;
  logic                             ev_any;

  // Traffic shaping knobs, shared by the test tasks and the receiver process.
  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;
  int ready_hold_cycles = 0;
  int mismatches = 0;

  // Shadow copy of the register state, updated once per accepted transfer.
  gpio_ed_pkg::fsel_word_t fsel_q [gpio_ed_pkg::FselWords] = '{default: '0};
  gpio_ed_pkg::pin_vec_t   latch_q = '0;
  gpio_ed_pkg::pin_vec_t   ren_q   = '0;
  gpio_ed_pkg::pin_vec_t   eds_q   = '0;
  gpio_ed_pkg::pin_vec_t   lev_q   = '0;

  // Responses predicted for accepted transfers, oldest first.
  gpio_resp_t pending_responses [$];

  // Pin levels of the last sample tick sent; random ticks mostly toggle a few of them.
  gpio_ed_pkg::pin_vec_t last_pins = '0;

  gpio_controller_edge_detect_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .op_i          (in_op),
    .word_addr_i   (in_addr),
    .write_data_i  (in_wdata),
    .pin_in_low_i  (in_pins_lo),
    .pin_in_high_i (in_pins_hi),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .read_data_o   (rd_data),
    .pin_out_low_o (pout_lo),
    .pin_out_high_o(pout_hi),
    .drive_low_o   (drv_lo),
    .drive_high_o  (drv_hi),
    .event_any_o   (ev_any)
  );

  // 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Applies one transfer to the shadow state and returns the response it should produce.
  function automatic gpio_resp_t predict_gpio_response(gpio_ed_pkg::op_e op,
                                                        logic [5:0] addr,
                                                        logic [31:0] wdata,
                                                        gpio_ed_pkg::pin_vec_t pins);
    gpio_resp_t              r;
    gpio_ed_pkg::fsel_word_t fw;
    gpio_ed_pkg::pin_vec_t   drv;
    r = '0;
    case (op)
      gpio_ed_pkg::OpRead: begin
        if (addr <= gpio_ed_pkg::AddrFselLast) begin
          r.read_data = 32'(fsel_q[addr[2:0]]);
        end else begin
          case (addr)
            gpio_ed_pkg::AddrLevLo:
              r.read_data = lev_q[gpio_ed_pkg::PinsLow-1:0];
            gpio_ed_pkg::AddrLevHi:
              r.read_data = 32'(lev_q[gpio_ed_pkg::NumPins-1:gpio_ed_pkg::PinsLow]);
            gpio_ed_pkg::AddrEdsLo:
              r.read_data = eds_q[gpio_ed_pkg::PinsLow-1:0];
            gpio_ed_pkg::AddrEdsHi:
              r.read_data = 32'(eds_q[gpio_ed_pkg::NumPins-1:gpio_ed_pkg::PinsLow]);
            gpio_ed_pkg::AddrRenLo:
              r.read_data = ren_q[gpio_ed_pkg::PinsLow-1:0];
            gpio_ed_pkg::AddrRenHi:
              r.read_data = 32'(ren_q[gpio_ed_pkg::NumPins-1:gpio_ed_pkg::PinsLow]);
            default: ;  // SET, CLR and unmapped words read as zero
          endcase
        end
      end
      gpio_ed_pkg::OpWrite: begin
        if (addr <= gpio_ed_pkg::AddrFselLast) begin
          // Fields of pins that do not exist are dropped.
          fw = wdata[gpio_ed_pkg::FselBits-1:0];
          for (int k = 0; k < gpio_ed_pkg::PinsPerWord; k++) begin
            if (int'(addr) * gpio_ed_pkg::PinsPerWord + k >= gpio_ed_pkg::NumPins)
              fw[gpio_ed_pkg::FieldBits*k +: gpio_ed_pkg::FieldBits] = '0;
          end
          fsel_q[addr[2:0]] = fw;
        end else begin
          case (addr)
            gpio_ed_pkg::AddrSetLo: latch_q[gpio_ed_pkg::PinsLow-1:0] =
                latch_q[gpio_ed_pkg::PinsLow-1:0] | wdata;
            gpio_ed_pkg::AddrSetHi: latch_q[gpio_ed_pkg::NumPins-1:gpio_ed_pkg::PinsLow] =
                latch_q[gpio_ed_pkg::NumPins-1:gpio_ed_pkg::PinsLow]
                | wdata[gpio_ed_pkg::PinsHigh-1:0];
            gpio_ed_pkg::AddrClrLo: latch_q[gpio_ed_pkg::PinsLow-1:0] =
                latch_q[gpio_ed_pkg::PinsLow-1:0] & ~wdata;
            gpio_ed_pkg::AddrClrHi: latch_q[gpio_ed_pkg::NumPins-1:gpio_ed_pkg::PinsLow] =
                latch_q[gpio_ed_pkg::NumPins-1:gpio_ed_pkg::PinsLow]
                & ~wdata[gpio_ed_pkg::PinsHigh-1:0];
            gpio_ed_pkg::AddrEdsLo: eds_q[gpio_ed_pkg::PinsLow-1:0] =
                eds_q[gpio_ed_pkg::PinsLow-1:0] & ~wdata;
            gpio_ed_pkg::AddrEdsHi: eds_q[gpio_ed_pkg::NumPins-1:gpio_ed_pkg::PinsLow] =
                eds_q[gpio_ed_pkg::NumPins-1:gpio_ed_pkg::PinsLow]
                & ~wdata[gpio_ed_pkg::PinsHigh-1:0];
            gpio_ed_pkg::AddrRenLo: ren_q[gpio_ed_pkg::PinsLow-1:0] = wdata;
            gpio_ed_pkg::AddrRenHi: ren_q[gpio_ed_pkg::NumPins-1:gpio_ed_pkg::PinsLow] =
                wdata[gpio_ed_pkg::PinsHigh-1:0];
            default: ;  // LEV and unmapped words ignore writes
          endcase
        end
      end
      gpio_ed_pkg::OpSample: begin
        // Rising edge: low at the previous tick, high now, and enabled.
        eds_q = eds_q | (pins & ~lev_q & ren_q);
        lev_q = pins;
      end
      default: ;  // idle changes nothing
    endcase
    drv = '0;
    for (int p = 0; p < gpio_ed_pkg::NumPins; p++) begin
      if (fsel_q[p / gpio_ed_pkg::PinsPerWord]
          [gpio_ed_pkg::FieldBits*(p % gpio_ed_pkg::PinsPerWord) +: gpio_ed_pkg::FieldBits]
          == gpio_ed_pkg::FuncOutput) begin
        drv[p] = 1'b1;
      end
    end
    r.pin_out_low  = latch_q[gpio_ed_pkg::PinsLow-1:0];
    r.pin_out_high = latch_q[gpio_ed_pkg::NumPins-1:gpio_ed_pkg::PinsLow];
    r.drive_low    = drv[gpio_ed_pkg::PinsLow-1:0];
    r.drive_high   = drv[gpio_ed_pkg::NumPins-1:gpio_ed_pkg::PinsLow];
    r.event_any    = |eds_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Monitor: output transfers are checked first, then an input transfer at the same
  // edge is predicted. Both sides are sampled at the rising edge, before any update.
  always @(posedge clk) begin : monitor
    gpio_resp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_responses.size() == 0) begin
          report_mismatch("unexpected result", rd_data, '0);
        end else begin
          want = pending_responses.pop_front();
          if (rd_data !== want.read_data) report_mismatch("read_data", rd_data, want.read_data);
          if (pout_lo !== want.pin_out_low)
            report_mismatch("pin_out_low", pout_lo, want.pin_out_low);
          if (pout_hi !== want.pin_out_high)
            report_mismatch("pin_out_high", 32'(pout_hi), 32'(want.pin_out_high));
          if (drv_lo !== want.drive_low) report_mismatch("drive_low", drv_lo, want.drive_low);
          if (drv_hi !== want.drive_high)
            report_mismatch("drive_high", 32'(drv_hi), 32'(want.drive_high));
          if (ev_any !== want.event_any)
            report_mismatch("event_any", 32'(ev_any), 32'(want.event_any));
        end
      end
      if (in_valid && in_ready) begin
        pending_responses.push_back(predict_gpio_response(gpio_ed_pkg::op_e'(in_op), in_addr,
                                                          in_wdata,
                                                          {in_pins_hi, in_pins_lo}));
      end
    end
  end

  // Receiver: random stalls, none while rx_stalls_on is clear, and a counted
  // hold-off whenever a test loads ready_hold_cycles.
  always @(negedge clk) begin
    if (ready_hold_cycles > 0) begin
      out_ready <= 1'b0;
      ready_hold_cycles = ready_hold_cycles - 1;
    end else if (!rx_stalls_on) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 29);
    end
  end

  // Offers one transfer, with an optional random gap first, and returns once it is
  // accepted. Valid stays high afterwards so back-to-back transfers need no toggle.
  task automatic send_op(gpio_ed_pkg::op_e op, logic [5:0] addr, logic [31:0] wdata,
                         logic [31:0] pins_lo, logic [gpio_ed_pkg::PinsHigh-1:0] pins_hi);
    @(negedge clk);
    if (tx_gaps_on && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 29);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_addr    <= addr;
    in_wdata   <= wdata;
    in_pins_lo <= pins_lo;
    in_pins_hi <= pins_hi;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender goes quiet until every predicted response has been taken.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  // Random transfer, mostly to mapped words, with sample ticks that toggle a few pins
  // so edges stay frequent but not universal.
  task automatic send_random_op();
    int                    pick;
    gpio_ed_pkg::op_e      op;
    logic [5:0]            addr;
    logic [31:0]           wdata;
    gpio_ed_pkg::pin_vec_t pins;
    pick = $urandom_range(99);
    op = (pick < 35) ? gpio_ed_pkg::OpRead :
         (pick < 68) ? gpio_ed_pkg::OpWrite :
         (pick < 96) ? gpio_ed_pkg::OpSample : gpio_ed_pkg::OpIdle;
    if ($urandom_range(9) == 0) begin
      addr = 6'($urandom_range(63));
    end else begin
      case ($urandom_range(15))
        0, 1, 2, 3, 4: addr = 6'($urandom_range(gpio_ed_pkg::AddrFselLast));
        5:  addr = gpio_ed_pkg::AddrSetLo;
        6:  addr = gpio_ed_pkg::AddrSetHi;
        7:  addr = gpio_ed_pkg::AddrClrLo;
        8:  addr = gpio_ed_pkg::AddrClrHi;
        9:  addr = gpio_ed_pkg::AddrLevLo;
        10: addr = gpio_ed_pkg::AddrLevHi;
        11: addr = gpio_ed_pkg::AddrEdsLo;
        12: addr = gpio_ed_pkg::AddrEdsHi;
        13: addr = gpio_ed_pkg::AddrRenLo;
        14: addr = gpio_ed_pkg::AddrRenHi;
        default: addr = ($urandom_range(1) != 0) ? gpio_ed_pkg::AddrEdsLo
                                                 : gpio_ed_pkg::AddrRenLo;
      endcase
    end
    case ($urandom_range(7))
      0: wdata = '1;
      1: wdata = '0;
      2: wdata = $urandom() & $urandom();
      default: wdata = $urandom();
    endcase
    // Plenty of output fields so drive enables move around.
    if (addr <= gpio_ed_pkg::AddrFselLast && $urandom_range(1) != 0) begin
      for (int k = 0; k < gpio_ed_pkg::PinsPerWord; k++) begin
        if ($urandom_range(1) != 0)
          wdata[gpio_ed_pkg::FieldBits*k +: gpio_ed_pkg::FieldBits] = gpio_ed_pkg::FuncOutput;
      end
    end
    case ($urandom_range(9))
      0: pins = gpio_ed_pkg::pin_vec_t'({$urandom(), $urandom()});
      1: pins = '1;
      2: pins = '0;
      default: pins = gpio_ed_pkg::pin_vec_t'(last_pins
                                              ^ ({$urandom(), $urandom()}
                                                 & {$urandom(), $urandom()}
                                                 & {$urandom(), $urandom()}));
    endcase
    if (op == gpio_ed_pkg::OpSample) last_pins = pins;
    send_op(op, addr, wdata, pins[gpio_ed_pkg::PinsLow-1:0],
            pins[gpio_ed_pkg::NumPins-1:gpio_ed_pkg::PinsLow]);
  endtask

  // Function select: masking of bits 30/31 and of the absent pins in the last word,
  // and pins turned to outputs in the first word and at pin 50 of the last word.
  task automatic test_function_select();
    send_op(gpio_ed_pkg::OpRead,  gpio_ed_pkg::AddrFselLast, '0, '0, '0);
    send_op(gpio_ed_pkg::OpWrite, 6'd0, '1, '0, '0);
    send_op(gpio_ed_pkg::OpRead,  6'd0, '0, '0, '0);
    send_op(gpio_ed_pkg::OpWrite, gpio_ed_pkg::AddrFselLast, '1, '0, '0);
    send_op(gpio_ed_pkg::OpRead,  gpio_ed_pkg::AddrFselLast, '0, '0, '0);
    send_op(gpio_ed_pkg::OpWrite, 6'd0, 32'h0924_9249, '0, '0);
    send_op(gpio_ed_pkg::OpWrite, gpio_ed_pkg::AddrFselLast, 32'hFFFF_FFF9, '0, '0);
  endtask

  // Output latch: set of both halves, partial low and full high clear, and a write-only readback.
  task automatic test_output_latch();
    send_op(gpio_ed_pkg::OpWrite, gpio_ed_pkg::AddrSetLo, '1, '0, '0);
    send_op(gpio_ed_pkg::OpWrite, gpio_ed_pkg::AddrSetHi, '1, '0, '0);
    send_op(gpio_ed_pkg::OpWrite, gpio_ed_pkg::AddrClrLo, 32'h5555_5555, '0, '0);
    send_op(gpio_ed_pkg::OpWrite, gpio_ed_pkg::AddrClrHi, '1, '0, '0);
    send_op(gpio_ed_pkg::OpRead,  gpio_ed_pkg::AddrSetHi, '0, '0, '0);
  endtask

  // Edge events: all pins rise, then fall, then the low status word is cleared and, of the high word, only pin 32.
  task automatic test_edge_events();
    send_op(gpio_ed_pkg::OpWrite,  gpio_ed_pkg::AddrRenLo, '1, '0, '0);
    send_op(gpio_ed_pkg::OpWrite,  gpio_ed_pkg::AddrRenHi, '1, '0, '0);
    send_op(gpio_ed_pkg::OpSample, '0, '0, '1, '1);
    send_op(gpio_ed_pkg::OpRead,   gpio_ed_pkg::AddrEdsHi, '0, '0, '0);
    send_op(gpio_ed_pkg::OpRead,   gpio_ed_pkg::AddrLevHi, '0, '0, '0);
    send_op(gpio_ed_pkg::OpSample, '0, '0, '0, '0);
    send_op(gpio_ed_pkg::OpWrite,  gpio_ed_pkg::AddrEdsLo, '1, '0, '0);
    send_op(gpio_ed_pkg::OpWrite,  gpio_ed_pkg::AddrEdsHi, 32'h0000_0001, '0, '0);
    send_op(gpio_ed_pkg::OpRead,   gpio_ed_pkg::AddrEdsHi, '0, '0, '0);
    last_pins = '0;
  endtask

  // Unmapped words, a write to the read-only level word, and the idle op.
  task automatic test_odd_words();
    send_op(gpio_ed_pkg::OpWrite, 6'd6, '1, '0, '0);
    send_op(gpio_ed_pkg::OpRead,  6'd63, '0, '0, '0);
    send_op(gpio_ed_pkg::OpWrite, gpio_ed_pkg::AddrLevLo, '1, '0, '0);
    send_op(gpio_ed_pkg::OpIdle,  gpio_ed_pkg::AddrEdsHi, '1, '1, '1);
  endtask

  task automatic test_random_traffic(int count);
    repeat (count) send_random_op();
  endtask

  // A stretch with neither side idling: one transfer per cycle.
  task automatic test_full_rate();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    repeat (300) send_random_op();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Receiver holds off for a long time while transfers keep coming, so the held
  // result blocks the input; afterwards the sender waits for the block to drain.
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;
    ready_hold_cycles = 150;
    repeat (40) send_random_op();
    wait_drained();
    tx_gaps_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_function_select();
    test_output_latch();
    test_edge_events();
    test_odd_words();
    test_random_traffic(700);
    test_full_rate();
    test_backpressure();
    test_random_traffic(760);
    wait_drained();
    // A few extra edges catch any stray result.
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("gpio_controller_edge_detect_unit regression: pass");
    end else begin
      $display("gpio_controller_edge_detect_unit regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #400_000;
    $display("gpio_controller_edge_detect_unit regression: fail");
    $finish;
  end

endmodule
